/* rtl/cmv_pkg.sv */
// Shared types, constants and modular add for the circulant matrix-vector block.
// No dependencies; every other file imports this package.
`default_nettype none

package cmv_pkg;

    localparam int WORD_W    = 32;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int MAX_N_DEF = 64;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;

    localparam logic [WORD_W-1:0] MOD_RESET = 32'd4294967291;

    // One classified input transaction, as handed from the front to the back
    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] gen;
        logic [IDX_W-1:0]  addr;
        logic [CNT_W-1:0]  n;
        logic              store;
        logic              start;
    } cmd_t;

    // Operands below p (or p zero: plain wrap)
    function automatic logic [WORD_W-1:0] add_mod(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] p);
        logic [WORD_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if ((p != '0) && (s >= {1'b0, p}))
            begin
                s = s - {1'b0, p};
            end
            return s[WORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/cmv_front.sv */
// Front end: accepts input transactions, tracks the load position and classifies each item.
// Depends on cmv_pkg.
`default_nettype none

module cmv_front
    import cmv_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [WORD_W-1:0]    in_x,
    input  wire logic [WORD_W-1:0]    in_gen,
    input  wire logic                 in_last,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output cmd_t                      push_cmd
);

    localparam int NW = $clog2(MAX_N + 1);

    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic          room;
    logic          accept;

    assign room       = (count_reg < NW'(MAX_N));
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        push_cmd       = '0;
        push_cmd.x     = in_x;
        push_cmd.gen   = in_gen;
        push_cmd.addr  = IDX_W'(count_reg);
        push_cmd.store = room;
        push_cmd.start = in_last;
        push_cmd.n     = room ? CNT_W'(count_reg + NW'(1)) : CNT_W'(count_reg);

        count_next = count_reg;
        if (accept)
        begin
            if (in_last)
            begin
                count_next = '0;
            end
            else if (room)
            begin
                count_next = count_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/cmv_queue.sv */
// Two-entry queue of classified transactions between the front and the back.
// Depends on cmv_pkg.
`default_nettype none

module cmv_queue
    import cmv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  cmd_t      push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/cmv_back.sv */
// Back end: element stores, sequencer and a bit-serial modular multiply pipeline
// with one stage per multiplier bit, plus the row accumulator and output register.
// Depends on cmv_pkg.
`default_nettype none

module cmv_back
    import cmv_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [WORD_W-1:0] modulus,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  cmd_t                   cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [WORD_W-1:0]      out_value,
    output logic [IDX_W-1:0]       out_index,
    output logic                   out_last
);

    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int NW = $clog2(MAX_N + 1);
    localparam int ST = WORD_W;

    typedef enum logic [1:0] {OP_LOAD_X, OP_LOAD_G, OP_PRE, OP_MAC} op_t;

    typedef struct packed {
        op_t           op;
        logic [AW-1:0] addr;
        logic [AW-1:0] row;
        logic          first;
        logic          last;
        logic          row_last;
    } meta_t;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD_G, S_WAIT_PRE, S_PRE, S_WAIT_MAC, S_MAC
    } state_t;

    state_t            state_reg, state_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [WORD_W-1:0] gen_hold_reg, gen_hold_next;
    logic              start_reg, start_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [AW-1:0]     k_reg, k_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_value_reg, out_value_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    logic              out_last_reg, out_last_next;

    logic [WORD_W-1:0] x_mem   [MAX_N];
    logic [WORD_W-1:0] gen_mem [MAX_N];
    logic [WORD_W-1:0] x_rd;
    logic [WORD_W-1:0] g_rd;
    logic [AW-1:0]     x_raddr;
    logic [AW-1:0]     g_raddr;

    logic              iss_valid;
    meta_t             iss_meta;
    logic [WORD_W-1:0] iss_imm;

    logic              r_valid_reg;
    meta_t             r_meta_reg;
    logic [WORD_W-1:0] r_imm_reg;

    logic [ST-1:0]     st_valid_reg;
    logic [WORD_W-1:0] st_acc_reg [ST];
    logic [WORD_W-1:0] st_a_reg   [ST];
    logic [WORD_W-1:0] st_b_reg   [ST];
    meta_t             st_meta_reg[ST];
    logic [WORD_W-1:0] st_acc_next[ST];
    logic [WORD_W-1:0] a0;
    logic [WORD_W-1:0] b0;

    logic              en;
    logic              busy;
    logic              tail_valid;
    meta_t             tail_meta;
    logic [WORD_W-1:0] tail_acc;
    logic              tail_done;
    logic [AW-1:0]     kidx;
    logic [NW:0]       kdiff;

    assign tail_valid = st_valid_reg[ST-1];
    assign tail_meta  = st_meta_reg[ST-1];
    assign tail_acc   = st_acc_reg[ST-1];
    assign tail_done  = tail_valid && (tail_meta.op == OP_MAC) && tail_meta.last;
    // Hold the whole pipeline while a finished row cannot leave
    assign en         = !(tail_done && out_valid_reg && !out_ready);
    assign busy       = r_valid_reg || (|st_valid_reg);
    assign cmd_ready  = (state_reg == S_IDLE) && en;

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_index  = out_index_reg;
    assign out_last   = out_last_reg;

    // Generator position for row i, column j: (j - i) mod n
    assign kdiff = (j_reg >= i_reg)
                 ? ((NW+1)'(j_reg) - (NW+1)'(i_reg))
                 : ((NW+1)'(n_reg) - (NW+1)'(i_reg) + (NW+1)'(j_reg));
    assign kidx  = kdiff[AW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        addr_next     = addr_reg;
        gen_hold_next = gen_hold_reg;
        start_next    = start_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        iss_valid     = 1'b0;
        iss_meta      = '0;
        iss_imm       = '0;
        x_raddr       = j_reg;
        g_raddr       = k_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && en)
                begin
                    n_next        = NW'(cmd.n);
                    addr_next     = AW'(cmd.addr);
                    gen_hold_next = cmd.gen;
                    start_next    = cmd.start;
                    if (cmd.store)
                    begin
                        iss_valid     = 1'b1;
                        iss_meta.op   = OP_LOAD_X;
                        iss_meta.addr = AW'(cmd.addr);
                        iss_imm       = cmd.x;
                        state_next    = S_LOAD_G;
                    end
                    else if (cmd.start)
                    begin
                        state_next = S_WAIT_PRE;
                    end
                end
            end
            S_LOAD_G:
            begin
                if (en)
                begin
                    iss_valid     = 1'b1;
                    iss_meta.op   = OP_LOAD_G;
                    iss_meta.addr = addr_reg;
                    iss_imm       = gen_hold_reg;
                    state_next    = start_reg ? S_WAIT_PRE : S_IDLE;
                end
            end
            S_WAIT_PRE:
            begin
                if (!busy)
                begin
                    k_next     = '0;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                // Re-reduce the generator by the modulus now in force
                if (en)
                begin
                    iss_valid     = 1'b1;
                    iss_meta.op   = OP_PRE;
                    iss_meta.addr = k_reg;
                    if ((NW'(k_reg) + NW'(1)) == n_reg)
                    begin
                        state_next = S_WAIT_MAC;
                    end
                    else
                    begin
                        k_next = k_reg + AW'(1);
                    end
                end
            end
            S_WAIT_MAC:
            begin
                if (!busy)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                g_raddr = kidx;
                if (en)
                begin
                    iss_valid         = 1'b1;
                    iss_meta.op       = OP_MAC;
                    iss_meta.row      = i_reg;
                    iss_meta.first    = (j_reg == '0);
                    iss_meta.last     = ((NW'(j_reg) + NW'(1)) == n_reg);
                    iss_meta.row_last = ((NW'(i_reg) + NW'(1)) == n_reg);
                    if ((NW'(j_reg) + NW'(1)) == n_reg)
                    begin
                        j_next = '0;
                        if ((NW'(i_reg) + NW'(1)) == n_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Row accumulator and output register
    always_comb
    begin
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        if (en && tail_valid && (tail_meta.op == OP_MAC))
        begin
            sum_next = add_mod(tail_meta.first ? '0 : sum_reg, tail_acc, modulus);
            if (tail_meta.last)
            begin
                out_valid_next = 1'b1;
                out_value_next = sum_next;
                out_index_next = IDX_W'(tail_meta.row);
                out_last_next  = tail_meta.row_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            addr_reg      <= '0;
            start_reg     <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            addr_reg      <= addr_next;
            start_reg     <= start_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gen_hold_reg  <= gen_hold_next;
        sum_reg       <= sum_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    // Element stores: registered read at issue, write from the pipeline tail
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_rd <= x_mem[x_raddr];
            g_rd <= gen_mem[g_raddr];
            if (tail_valid)
            begin
                case (tail_meta.op) inside
                    OP_LOAD_X:
                    begin
                        x_mem[tail_meta.addr] <= tail_acc;
                    end
                    OP_LOAD_G, OP_PRE:
                    begin
                        gen_mem[tail_meta.addr] <= tail_acc;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Operand selection: loads and re-reduction compute 1 * b mod p
    always_comb
    begin
        a0 = (r_meta_reg.op == OP_MAC) ? g_rd : WORD_W'(1);
        case (r_meta_reg.op) inside
            OP_LOAD_X, OP_LOAD_G: b0 = r_imm_reg;
            OP_PRE:               b0 = g_rd;
            default:              b0 = x_rd;
        endcase
    end

    // Double-and-add, one multiplier bit per stage, most significant first
    always_comb
    begin
        logic [WORD_W-1:0] acc_in;
        logic [WORD_W-1:0] a_in;
        logic [WORD_W-1:0] b_in;
        logic [WORD_W-1:0] d;
        for (int t = 0; t < ST; t++)
        begin
            acc_in = (t == 0) ? '0 : st_acc_reg[(t == 0) ? 0 : t - 1];
            a_in   = (t == 0) ? a0 : st_a_reg[(t == 0) ? 0 : t - 1];
            b_in   = (t == 0) ? b0 : st_b_reg[(t == 0) ? 0 : t - 1];
            d      = add_mod(acc_in, acc_in, modulus);
            if (b_in[ST-1-t])
            begin
                d = add_mod(d, a_in, modulus);
            end
            st_acc_next[t] = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg  <= 1'b0;
            st_valid_reg <= '0;
        end
        else if (en)
        begin
            r_valid_reg  <= iss_valid;
            st_valid_reg <= {st_valid_reg[ST-2:0], r_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_meta_reg     <= iss_meta;
            r_imm_reg      <= iss_imm;
            st_acc_reg[0]  <= st_acc_next[0];
            st_a_reg[0]    <= a0;
            st_b_reg[0]    <= b0;
            st_meta_reg[0] <= r_meta_reg;
            for (int t = 1; t < ST; t++)
            begin
                st_acc_reg[t]  <= st_acc_next[t];
                st_a_reg[t]    <= st_a_reg[t-1];
                st_b_reg[t]    <= st_b_reg[t-1];
                st_meta_reg[t] <= st_meta_reg[t-1];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/circulant_matvec_mod_p.sv */
// Circulant matrix-vector product modulo p: top level with the modulus register.
// Depends on cmv_pkg, cmv_front, cmv_queue and cmv_back.
//
// Usage: each slave-side transaction carries one element pair (x in tdata[31:0],
// generator in tdata[63:32]); tlast marks the final pair of a run. Pairs past
// MAX_N are dropped. After the last pair the block emits n master-side
// transactions, y[i] in tdata[31:0] and i in tdata[37:32], tlast on i = n - 1.
// The user writes the modulus on the cfg channel (always ready) only while the block
// is idle, which the block itself does not enforce; zero means plain wrap at 32 bits.
// Loading costs two slots of the 32-stage multiply pipeline per pair. A run waits for
// the last pair's loads to leave the pipeline, issues n re-reductions of the generator,
// waits for those to leave as well, then issues n*n multiply-accumulates, one product
// per cycle through the shared pipeline while the output does not stall it.
// A stalled receiver freezes the pipeline once the next finished row meets the
// full output register; nothing is lost.
// Reset clears the load position, queue, sequencer and output valid and loads
// modulus 4294967291; the element stores need no clearing.
`default_nettype none

module circulant_matvec_mod_p
    import cmv_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // x_value, gen_value
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // y_value, y_index, zero pad
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [WORD_W-1:0]     cfg_data       // modulus
);

    logic [WORD_W-1:0] modulus_reg;
    logic              push_valid;
    logic              push_ready;
    cmd_t              push_cmd;
    logic              pop_valid;
    logic              pop_ready;
    cmd_t              pop_cmd;
    logic [WORD_W-1:0] y_value;
    logic [IDX_W-1:0]  y_index;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
        end
        else if (cfg_valid)
        begin
            modulus_reg <= cfg_data;
        end
    end

    cmv_front #(.MAX_N(MAX_N)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_x       (s_axis_tdata[WORD_W-1:0]),
        .in_gen     (s_axis_tdata[2*WORD_W-1:WORD_W]),
        .in_last    (s_axis_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    cmv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    cmv_back #(.MAX_N(MAX_N)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .modulus    (modulus_reg),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd        (pop_cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (y_value),
        .out_index  (y_index),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_DATA_W - WORD_W - IDX_W)'(0), y_index, y_value};

endmodule

`default_nettype wire

/* bench/cmv_checker.sv */
// Checker for circulant_matvec_mod_p: follows the modulus writes and the element loads,
// predicts every result row and compares the master-side transactions against it.
// Depends on cmv_pkg for the port widths.
module cmv_checker
    import cmv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  m_tlast,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [WORD_W-1:0]     cfg_data,
    output int                         fail_count,
    output int                         rows_pending,
    output int                         runs_seen,
    output int                         rows_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    typedef struct {
        logic [WORD_W-1:0] y;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } row_t;

    row_t              expected_rows[$];
    logic [WORD_W-1:0] modulus;
    logic [WORD_W-1:0] x_mem[DEPTH];
    logic [WORD_W-1:0] gen_mem[DEPTH];
    int                load_count;

    function automatic logic [WORD_W-1:0] residue(input logic [WORD_W-1:0] v,
                                                  input logic [WORD_W-1:0] p);
        if (p == '0)
            return v;
        return v % p;
    endfunction

    // acc + a*b, reduced by p; p zero wraps at the word width
    function automatic logic [WORD_W-1:0] mac_mod(input logic [WORD_W-1:0] acc,
                                                  input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] p);
        logic [63:0] prod;
        logic [63:0] total;
        prod = 64'(a) * 64'(b);
        if (p == '0)
            return acc + prod[WORD_W-1:0];
        prod  = prod % 64'(p);
        total = (64'(acc % p) + prod) % 64'(p);
        return total[WORD_W-1:0];
    endfunction

    task automatic predict_rows(input int n);
        logic [WORD_W-1:0] acc;
        row_t              r;
        for (int i = 0; i < n; i++)
        begin
            acc = '0;
            for (int j = 0; j < n; j++)
                acc = mac_mod(acc, gen_mem[(j + n - i) % n], x_mem[j], modulus);
            r.y    = acc;
            r.idx  = IDX_W'(i);
            r.last = (i == n - 1);
            expected_rows.push_back(r);
        end
    endtask

    assign rows_pending = expected_rows.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus    = MOD_RESET;
            load_count = 0;
            fail_count = 0;
            runs_seen  = 0;
            rows_seen  = 0;
            expected_rows.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                modulus = cfg_data;
            if (s_tvalid && s_tready)
            begin
                // drop pairs past the store depth
                if (load_count < DEPTH)
                begin
                    x_mem[load_count]   = residue(s_tdata[31:0], modulus);
                    gen_mem[load_count] = residue(s_tdata[63:32], modulus);
                    load_count++;
                end
                if (s_tlast)
                begin
                    predict_rows(load_count);
                    load_count = 0;
                    runs_seen++;
                end
            end
            if (m_tvalid && m_tready)
            begin
                rows_seen++;
                if (expected_rows.size() == 0)
                begin
                    $error("unexpected result transaction: y_value %0h", m_tdata[31:0]);
                    fail_count++;
                end
                else
                begin
                    row_t r;
                    r = expected_rows.pop_front();
                    if (m_tdata[31:0] !== r.y)
                    begin
                        $error("y_value: expected %0h, got %0h", r.y, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[37:32] !== r.idx)
                    begin
                        $error("y_index: expected %0d, got %0d", r.idx, m_tdata[37:32]);
                        fail_count++;
                    end
                    if (m_tlast !== r.last)
                    begin
                        $error("last_result: expected %0b, got %0b", r.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* bench/tb_top.sv */
// Top of the circulant_matvec_mod_p bench: clock, reset, stimulus and verdict.
// Depends on cmv_pkg, the block itself and cmv_checker.
module tb_top
    import cmv_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int ITEM_TARGET = 320;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [WORD_W-1:0]     cfg_data = '0;

    int fail_count;
    int rows_pending;
    int runs_seen;
    int rows_seen;
    int cycles = 0;
    int items_sent = 0;
    bit no_idle = 1'b0;
    logic [WORD_W-1:0] cur_mod = MOD_RESET;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    circulant_matvec_mod_p i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    cmv_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_axis_tvalid),
        .s_tready     (s_axis_tready),
        .s_tdata      (s_axis_tdata),
        .s_tlast      (s_axis_tlast),
        .m_tvalid     (m_axis_tvalid),
        .m_tready     (m_axis_tready),
        .m_tdata      (m_axis_tdata),
        .m_tlast      (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .rows_pending (rows_pending),
        .runs_seen    (runs_seen),
        .rows_seen    (rows_seen)
    );

    // receiver stalls at random, except in quiet stretches
    always @(posedge clk)
        m_axis_tready <= no_idle || ($urandom_range(99) >= 9);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("circulant_matvec_mod_p verification failed");
            $finish;
        end
    end

    task automatic push_pair(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] g,
                             input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {g, x};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (!no_idle && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge clk);
    endtask

    // hold until the block has drained, then let the pipeline settle
    task automatic drain();
        while (rows_pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [WORD_W-1:0] p);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_mod = p;
        @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return (cur_mod == '0) ? '1 : cur_mod - 1;
            3: return cur_mod;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_vector(input int n);
        for (int i = 0; i < n; i++)
            push_pair(pick_value(), pick_value(), i == n - 1);
        end_burst();
    endtask

    function automatic logic [WORD_W-1:0] pick_modulus();
        case ($urandom_range(7))
            0: return 32'd2;
            1: return 32'd1;
            2: return '0;
            3: return '1;
            4: return MOD_RESET;
            5: return 32'd7;
            default: return $urandom_range(32'hFFFF_FFFF, 2);
        endcase
    endfunction

    initial
    begin
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed: single pair and extremes at the reset modulus
        push_pair('1, '1, 1'b1);
        end_burst();
        push_pair('0, '1, 1'b0);
        push_pair('1, '0, 1'b0);
        push_pair(MOD_RESET, 32'hFFFF_FFFC, 1'b1);
        end_burst();
        write_modulus(32'd1);
        run_vector(3);
        write_modulus('0);
        push_pair('1, '1, 1'b0);
        push_pair(32'h8000_0000, 32'h8000_0001, 1'b1);
        end_burst();
        write_modulus(32'd2);
        run_vector(4);
        // modulus changed part way through a load
        write_modulus('1);
        push_pair('1, 32'hFFFF_FFFE, 1'b0);
        push_pair(32'd5, 32'hDEAD_BEEF, 1'b0);
        end_burst();
        write_modulus(32'd13);
        push_pair(32'd100, 32'd27, 1'b1);
        end_burst();
        // overflowing load: pairs past the store depth are dropped
        write_modulus('1);
        no_idle = 1'b1;
        run_vector(67);
        no_idle = 1'b0;

        // random runs, mostly short, a few at full depth
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(5) == 0)
                write_modulus(pick_modulus());
            else if ($urandom_range(9) == 0)
                drain();
            no_idle = (items_sent > 180 && items_sent < 240);
            case ($urandom_range(39))
                0: n = 64;
                1: n = 66;
                default: n = $urandom_range(1, 8);
            endcase
            run_vector(n);
        end
        no_idle = 1'b0;

        drain();
        $display("%0d pairs loaded over %0d runs, %0d result rows compared", items_sent,
                 runs_seen, rows_seen);
        $display("moduli covered include 0, 1, 2, 2^32-1 and mid-load changes");
        if (fail_count == 0)
            $display("circulant_matvec_mod_p verification clean");
        else
            $display("circulant_matvec_mod_p verification failed");
        $finish;
    end

endmodule
